// File: rtl/v3n_pkg.sv
// Shared types for the 3D vector normalization core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package v3n_pkg;

    localparam int unsigned COMP_W = 16;
    localparam int unsigned SUM_W  = 32;
    localparam int unsigned ROOT_W = 16;
    localparam int unsigned QUO_W  = 15;
    localparam int unsigned REM_W  = 19;
    localparam int unsigned DREM_W = 17;

    typedef struct packed {
        logic signed [COMP_W-1:0] vec_x;
        logic signed [COMP_W-1:0] vec_y;
        logic signed [COMP_W-1:0] vec_z;
    } t_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic        [COMP_W-1:0] vector_length;
        logic                     degenerate;
    } t_out;

    typedef struct packed {
        logic [COMP_W-1:0] mag_x;
        logic [COMP_W-1:0] mag_y;
        logic [COMP_W-1:0] mag_z;
        logic              neg_x;
        logic              neg_y;
        logic              neg_z;
    } t_mag;

    typedef struct packed {
        t_mag              m;
        logic [ROOT_W-1:0] len;
        logic              degen;
    } t_dside;

endpackage

`default_nettype wire

// File: rtl/v3n_sumsq.sv
// Magnitude, square and sum stages of the normalization pipeline.
// Depends on v3n_pkg.
`timescale 1ns / 1ps
`default_nettype none

module v3n_sumsq import v3n_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_in               i_data,
    output logic                   o_valid,
    output logic [SUM_W-1:0]       o_sum,
    output t_mag                   o_mag
);

    logic              r_va, r_vb, r_vc;
    t_mag              r_ma, r_mb, r_mc;
    t_mag              n_ma;
    logic [SUM_W-1:0]  r_sx, r_sy, r_sz, r_sum;

    // Magnitudes of two's complement components; -32768 becomes 32768.
    always_comb begin
        n_ma.neg_x = i_data.vec_x[COMP_W-1];
        n_ma.neg_y = i_data.vec_y[COMP_W-1];
        n_ma.neg_z = i_data.vec_z[COMP_W-1];
        n_ma.mag_x = n_ma.neg_x ? (~i_data.vec_x + 1'b1) : i_data.vec_x;
        n_ma.mag_y = n_ma.neg_y ? (~i_data.vec_y + 1'b1) : i_data.vec_y;
        n_ma.mag_z = n_ma.neg_z ? (~i_data.vec_z + 1'b1) : i_data.vec_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma  <= n_ma;
            r_mb  <= r_ma;
            r_sx  <= r_ma.mag_x * r_ma.mag_x;
            r_sy  <= r_ma.mag_y * r_ma.mag_y;
            r_sz  <= r_ma.mag_z * r_ma.mag_z;
            r_mc  <= r_mb;
            r_sum <= r_sx + r_sy + r_sz;
        end
    end

    assign o_valid = r_vc;
    assign o_sum   = r_sum;
    assign o_mag   = r_mc;

endmodule

`default_nettype wire

// File: rtl/v3n_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on v3n_pkg.
`timescale 1ns / 1ps
`default_nettype none

module v3n_isqrt import v3n_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [SUM_W-1:0]  i_sum,
    input  wire t_mag              i_mag,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_root,
    output t_mag                   o_mag
);

    logic              r_v    [0:ROOT_W-1];
    logic [SUM_W-1:0]  r_sum  [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    t_mag              r_mag  [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            localparam int unsigned HI = SUM_W - 1 - 2*k;
            logic              v_in;
            logic [SUM_W-1:0]  sum_in;
            logic [REM_W-1:0]  rem_in, cur, trial, n_rem;
            logic [ROOT_W-1:0] root_in, n_root;
            t_mag              mag_in;

            if (k == 0) begin : g_first
                assign v_in    = i_valid;
                assign sum_in  = i_sum;
                assign rem_in  = '0;
                assign root_in = '0;
                assign mag_in  = i_mag;
            end else begin : g_next
                assign v_in    = r_v[k-1];
                assign sum_in  = r_sum[k-1];
                assign rem_in  = r_rem[k-1];
                assign root_in = r_root[k-1];
                assign mag_in  = r_mag[k-1];
            end

            // Bring down two bits of the radicand and try root*4+1.
            always_comb begin
                cur   = {rem_in[REM_W-3:0], sum_in[HI -: 2]};
                trial = {1'b0, root_in, 2'b01};
                if (cur >= trial) begin
                    n_rem  = cur - trial;
                    n_root = {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = cur;
                    n_root = {root_in[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sum[k]  <= sum_in;
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                    r_mag[k]  <= mag_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_mag   = r_mag[ROOT_W-1];

endmodule

`default_nettype wire

// File: rtl/v3n_qdiv.sv
// Pipelined restoring divider for the three Q2.14 quotients plus the result stage.
// Depends on v3n_pkg.
`timescale 1ns / 1ps
`default_nettype none

module v3n_qdiv import v3n_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_dside            i_side,
    output logic                   o_valid,
    output t_out                   o_data
);

    logic              r_v    [0:QUO_W-1];
    t_dside            r_side [0:QUO_W-1];
    logic [DREM_W-1:0] r_rem  [0:QUO_W-1][0:2];
    logic [QUO_W-1:0]  r_quo  [0:QUO_W-1][0:2];
    logic              r_ov;
    t_out              r_out;
    t_out              n_out;

    genvar j;
    generate
        for (j = 0; j < QUO_W; j++) begin : g_stage
            logic              v_in;
            t_dside            side_in;
            logic [DREM_W-1:0] rem_in [0:2];
            logic [QUO_W-1:0]  quo_in [0:2];
            logic [DREM_W-1:0] n_rem  [0:2];
            logic [QUO_W-1:0]  n_quo  [0:2];
            logic              nbit   [0:2];

            if (j == 0) begin : g_first
                // Numerator is mag * 2^14; the upper part mag/2 is already below len.
                assign v_in      = i_valid;
                assign side_in   = i_side;
                assign rem_in[0] = {2'b00, i_side.m.mag_x[COMP_W-1:1]};
                assign rem_in[1] = {2'b00, i_side.m.mag_y[COMP_W-1:1]};
                assign rem_in[2] = {2'b00, i_side.m.mag_z[COMP_W-1:1]};
                assign nbit[0]   = i_side.m.mag_x[0];
                assign nbit[1]   = i_side.m.mag_y[0];
                assign nbit[2]   = i_side.m.mag_z[0];
                assign quo_in[0] = '0;
                assign quo_in[1] = '0;
                assign quo_in[2] = '0;
            end else begin : g_next
                assign v_in    = r_v[j-1];
                assign side_in = r_side[j-1];
                for (genvar c = 0; c < 3; c++) begin : g_c
                    assign rem_in[c] = r_rem[j-1][c];
                    assign quo_in[c] = r_quo[j-1][c];
                    assign nbit[c]   = 1'b0;
                end
            end

            always_comb begin
                logic [DREM_W-1:0] cur;
                logic [DREM_W-1:0] dvs;
                dvs = {1'b0, side_in.len};
                for (int c = 0; c < 3; c++) begin
                    cur = {rem_in[c][DREM_W-2:0], nbit[c]};
                    if (cur >= dvs) begin
                        n_rem[c] = cur - dvs;
                        n_quo[c] = {quo_in[c][QUO_W-2:0], 1'b1};
                    end else begin
                        n_rem[c] = cur;
                        n_quo[c] = {quo_in[c][QUO_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (i_en) begin
                    r_v[j] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[j] <= side_in;
                    for (int c = 0; c < 3; c++) begin
                        r_rem[j][c] <= n_rem[c];
                        r_quo[j][c] <= n_quo[c];
                    end
                end
            end
        end
    endgenerate

    // Apply signs and the degenerate mask.
    always_comb begin
        t_dside s;
        logic [COMP_W-1:0] qx, qy, qz;
        s  = r_side[QUO_W-1];
        qx = {1'b0, r_quo[QUO_W-1][0]};
        qy = {1'b0, r_quo[QUO_W-1][1]};
        qz = {1'b0, r_quo[QUO_W-1][2]};
        n_out.vector_length = s.len;
        n_out.degenerate    = s.degen;
        if (s.degen) begin
            n_out.unit_x = '0;
            n_out.unit_y = '0;
            n_out.unit_z = '0;
        end else begin
            n_out.unit_x = s.m.neg_x ? (~qx + 1'b1) : qx;
            n_out.unit_y = s.m.neg_y ? (~qy + 1'b1) : qy;
            n_out.unit_z = s.m.neg_z ? (~qz + 1'b1) : qz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// File: rtl/vector3_normalize_core.sv
// Top level of the 3D vector normalization core.
// Depends on v3n_pkg, v3n_sumsq, v3n_isqrt and v3n_qdiv.
`timescale 1ns / 1ps
`default_nettype none

// The core takes one signed 16-bit vector per transfer and returns its truncated
// Euclidean length together with the unit vector in signed Q2.14, each component
// truncated toward zero. A vector whose length is below min_length (or is zero)
// comes back as a zero vector with the degenerate flag set; its length is still
// reported. The pipeline accepts one vector every cycle unless it is stalled, and
// has three stages for magnitudes, squares and their sum, sixteen stages of
// the bit-per-stage square root, one stage for the minimum-length compare, fifteen
// stages of the restoring divider that produces the three quotients in parallel,
// and one result stage that drives the output. The whole pipeline advances as one
// unit; it halts only while a finished result is held on the output and the
// downstream side stalls, so o_stall follows i_stall in that case alone. The
// min_length register is written over its own channel, which is always ready, and
// should only change while no vector is in flight.
module vector3_normalize_core import v3n_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire t_in               i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output t_out                   o_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [COMP_W-1:0] i_cfg_data
);

    logic              adv;
    logic [COMP_W-1:0] r_min_length;

    logic              sq_valid;
    logic [SUM_W-1:0]  sq_sum;
    t_mag              sq_mag;

    logic              rt_valid;
    logic [ROOT_W-1:0] rt_root;
    t_mag              rt_mag;

    logic              r_dv;
    t_dside            r_side;

    // Everything moves together unless a held result is being stalled.
    assign adv         = !(o_valid && i_stall);
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= COMP_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_length <= i_cfg_data;
        end
    end

    v3n_sumsq u_sumsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (sq_valid),
        .o_sum   (sq_sum),
        .o_mag   (sq_mag)
    );

    v3n_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (sq_valid),
        .i_sum   (sq_sum),
        .i_mag   (sq_mag),
        .o_valid (rt_valid),
        .o_root  (rt_root),
        .o_mag   (rt_mag)
    );

    // A zero length is always degenerate, even with min_length at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (adv) begin
            r_dv <= rt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side.m     <= rt_mag;
            r_side.len   <= rt_root;
            r_side.degen <= (rt_root < r_min_length) || (rt_root == '0);
        end
    end

    v3n_qdiv u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_dv),
        .i_side  (r_side),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for vector3_normalize_core.
// Depends on v3n_pkg and the core; drives random and directed vectors and checks each result.
`timescale 1ns / 1ps

module tb;
    import v3n_pkg::*;

    // Pipeline depth of the core; settle windows are sized from it.
    localparam int PIPE_LAT = 36;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in         in_data;
    logic        out_valid;
    logic        out_stall;
    t_out        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Predictor copy of the one register.
    logic [15:0] min_len_model;

    t_out expected_q[$];
    int   error_count;
    int   sent_count;
    int   checked_count;
    int   degen_count;
    int   hold_cycles;   // When nonzero, the receiver stalls for that many cycles.
    bit   rand_stall_on;

    vector3_normalize_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (out_stall),
        .i_data      (in_data),
        .o_valid     (out_valid),
        .i_stall     (in_stall),
        .o_data      (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Truncated integer square root, worked out one result bit at a time.
    function automatic logic [15:0] int_sqrt(input logic [31:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= 64'(v)) begin
                r = t;
            end
        end
        return r[15:0];
    endfunction

    // Expected normalization of one vector under the current minimum length.
    function automatic t_out normalize_vec(input t_in v);
        t_out        r;
        int          cx, cy, cz;
        int          qx, qy, qz;
        logic [31:0] sum;
        cx = v.vec_x;
        cy = v.vec_y;
        cz = v.vec_z;
        sum = 32'(cx * cx) + 32'(cy * cy) + 32'(cz * cz);
        r = '0;
        r.vector_length = int_sqrt(sum);
        if (r.vector_length < min_len_model || r.vector_length == 0) begin
            r.degenerate = 1'b1;
        end else begin
            // SystemVerilog integer division already truncates toward zero.
            qx = (cx * 16384) / int'(r.vector_length);
            qy = (cy * 16384) / int'(r.vector_length);
            qz = (cz * 16384) / int'(r.vector_length);
            r.unit_x = 16'(qx);
            r.unit_y = 16'(qy);
            r.unit_z = 16'(qz);
        end
        return r;
    endfunction

    // Sends one vector after a random gap unless no_gap is set; the prediction is queued at acceptance.
    task automatic send_vector(input t_in v, input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        @(posedge clk);
        while (out_stall) @(posedge clk);
        expected_q.push_back(normalize_vec(v));
        sent_count++;
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits for every result, then lets the pipeline settle so nothing is in flight.
    task automatic drain();
        release_input();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic write_min_length(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        min_len_model = value;
    endtask

    function automatic t_in make_vec(input int x, input int y, input int z);
        t_in v;
        v.vec_x = 16'(x);
        v.vec_y = 16'(y);
        v.vec_z = 16'(z);
        return v;
    endfunction

    function automatic t_in rand_vec();
        t_in v;
        int  sel;
        sel = $urandom_range(0, 3);
        v = t_in'({$urandom(), $urandom()});
        // Mix in short vectors so the minimum-length compare sees both outcomes.
        if (sel == 0) begin
            v = make_vec($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                         $urandom_range(0, 64) - 32);
        end else if (sel == 1) begin
            v = make_vec($urandom_range(0, 2048) - 1024, $urandom_range(0, 2048) - 1024,
                         $urandom_range(0, 2048) - 1024);
        end
        return v;
    endfunction

    // Receiver side: random stalls, an optional long hold-off, and result checks.
    initial begin : result_checker
        t_out want;
        int   wait_left;
        wait_left = 0;
        in_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && !in_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    checked_count++;
                    if (want.degenerate) degen_count++;
                    if (want.unit_x !== out_data.unit_x)
                        $display("%0t: unit_x expected %0d actual %0d", $time,
                                 want.unit_x, out_data.unit_x);
                    if (want.unit_y !== out_data.unit_y)
                        $display("%0t: unit_y expected %0d actual %0d", $time,
                                 want.unit_y, out_data.unit_y);
                    if (want.unit_z !== out_data.unit_z)
                        $display("%0t: unit_z expected %0d actual %0d", $time,
                                 want.unit_z, out_data.unit_z);
                    if (want.vector_length !== out_data.vector_length)
                        $display("%0t: vector_length expected %0d actual %0d", $time,
                                 want.vector_length, out_data.vector_length);
                    if (want.degenerate !== out_data.degenerate)
                        $display("%0t: degenerate expected %0b actual %0b", $time,
                                 want.degenerate, out_data.degenerate);
                    if (want !== out_data) error_count++;
                end
            end
            // Decide the stall for the next cycle.
            if (hold_cycles > 0) begin
                hold_cycles--;
                in_stall <= 1'b1;
            end else if (wait_left > 0) begin
                wait_left--;
                in_stall <= 1'b1;
            end else begin
                in_stall <= 1'b0;
                if (rand_stall_on && $urandom_range(0, 2) == 0)
                    wait_left = $urandom_range(0, 15);
            end
        end
    end

    task automatic test_extremes();
        int vals[5] = '{-32768, -1, 0, 1, 32767};
        write_min_length(16'd1);
        foreach (vals[i]) send_vector(make_vec(vals[i], vals[4 - i], vals[(i + 2) % 5]));
        send_vector(make_vec(-32768, -32768, -32768));
        send_vector(make_vec(32767, 32767, 32767));
        send_vector(make_vec(0, 0, 0));
        send_vector(make_vec(1, 0, 0));    // length exactly 1 is still normalized
        send_vector(make_vec(0, -1, 0));
        send_vector(make_vec(-32768, 0, 0));
        send_vector(make_vec(0, 0, 32767));
        send_vector(make_vec(3, 4, 12));
        drain();
    endtask

    task automatic test_min_length();
        // Zero minimum: only a zero-length vector is degenerate.
        write_min_length(16'd0);
        send_vector(make_vec(0, 0, 0));
        send_vector(make_vec(0, 1, 0));
        drain();
        // Lengths just below and at the threshold.
        write_min_length(16'd13);
        send_vector(make_vec(3, 4, 12));
        send_vector(make_vec(3, 4, 11));
        send_vector(make_vec(-3, -4, -13));
        drain();
        // Maximum: every vector is degenerate, length still reported.
        write_min_length(16'hFFFF);
        send_vector(make_vec(32767, -32768, 32767));
        send_vector(make_vec(-32768, -32768, -32768));
        drain();
    endtask

    task automatic test_random(input int n, input logic [15:0] min_len);
        write_min_length(min_len);
        rand_stall_on = 1'b1;
        for (int i = 0; i < n; i++) send_vector(rand_vec(), ($urandom_range(0, 4) == 0));
        drain();
    endtask

    // Receiver holds off while vectors keep coming, so the pipeline backs up.
    task automatic test_backpressure();
        write_min_length(16'd1);
        rand_stall_on = 1'b0;
        hold_cycles = 200;
        for (int i = 0; i < 80; i++) send_vector(rand_vec(), 1'b1);
        drain();
        rand_stall_on = 1'b1;
    endtask

    initial begin : stimulus
        error_count   = 0;
        sent_count    = 0;
        checked_count = 0;
        degen_count   = 0;
        hold_cycles   = 0;
        rand_stall_on = 1'b0;
        min_len_model = 16'd1;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_min_length();
        test_backpressure();
        test_random(500, 16'd1);
        test_random(300, 16'd0);
        test_random(300, 16'd40);
        test_random(250, 16'($urandom_range(0, 65535)));

        $display("Covered %0d vectors, %0d results checked, %0d degenerate.",
                 sent_count, checked_count, degen_count);
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #3ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: vector3_normalize_core.f
rtl/v3n_pkg.sv
rtl/v3n_sumsq.sv
rtl/v3n_isqrt.sv
rtl/v3n_qdiv.sv
rtl/vector3_normalize_core.sv
test/tb.sv
